FILE: design/dmwf_pkg.sv
// ============================================================================
// dmwf_pkg
// Types and codes shared by the duplicate message window filter and its
// checker.
// ============================================================================
package dmwf_pkg;

    // Action codes carried in the action field of an input item
    typedef enum logic [1:0] {
        ACT_CHECK_RECORD = 2'd0,
        ACT_CHECK        = 2'd1,
        ACT_RECORD       = 2'd2,
        ACT_CLEAR        = 2'd3
    } t_action;

    // One input item
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] src_node;
        logic [63:0] msg_id;
        logic [63:0] timestamp_us;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic       dup_found;
        logic       stored;
        logic [6:0] slot_written;
        logic       status;
    } t_out_item;

endpackage

FILE: design/duplicate_message_window_filter_unit.sv
// A lookup or record item passes from accept through the scan, drain, decide
// and finish states, and finish loads the result register; a clear item goes
// straight to finish. No new item is taken until finish is left; the scan reads
// one window entry per cycle through the single read port.
// Reset: synchronous, active low; empties the window by zeroing the fill
// count and fill pointer, so no clearing pass over the memory is needed.
// ============================================================================
// duplicate_message_window_filter_unit
// Sliding window of recent (source, message id) pairs with timestamps.
// A sequencer scans the entry memory one entry per cycle through a shared
// match and minimum-timestamp unit, then writes at most one entry.
// ============================================================================
module duplicate_message_window_filter_unit
    import dmwf_pkg::*;
#(
    parameter int WINDOW_DEPTH = 128,
    parameter int NODE_ID_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int SRC_W = (NODE_ID_BITS < 16) ? NODE_ID_BITS : 16;

    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic [63:0]      msg;
        logic [63:0]      ts;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_FINISH
    } t_state;

    // Entry memory and its registered read port
    t_entry r_mem [WINDOW_DEPTH];
    t_entry r_rd_data;

    t_state            r_state;
    t_in_item          r_item;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic              r_rd_vld;
    logic              r_hit;
    logic [63:0]       r_best_ts;
    logic [IDX_W-1:0]  r_best_idx;
    logic [IDX_W-1:0]  r_fill_ptr;
    logic [CNT_W-1:0]  r_fill_cnt;
    t_out_item         r_res;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              w_full;
    logic              w_we;
    logic [IDX_W-1:0]  w_slot;
    logic [IDX_W+6:0]  w_slot_ext;
    t_out_item         w_res;
    t_entry            w_wdata;
    logic              w_in_acc;
    logic              w_out_free;
    logic              w_entry_vld;
    logic              w_match;
    logic              w_older;

    assign w_full      = (r_fill_cnt == CNT_W'(WINDOW_DEPTH));
    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_slot      = w_full ? r_best_idx : r_fill_ptr;
    assign w_slot_ext  = {7'd0, w_slot};

    // Shared compare unit: match against the item, and oldest-entry search
    assign w_entry_vld = ({1'b0, r_cmp_idx} < r_fill_cnt);
    assign w_match     = w_entry_vld && (r_rd_data.src == r_item.src_node[SRC_W-1:0])
                         && (r_rd_data.msg == r_item.msg_id);
    assign w_older     = (r_cmp_idx == '0) || (r_rd_data.ts < r_best_ts);

    assign w_wdata.src = r_item.src_node[SRC_W-1:0];
    assign w_wdata.msg = r_item.msg_id;
    assign w_wdata.ts  = r_item.timestamp_us;

    // Decision once the scan is complete
    always_comb begin
        w_res = '0;
        w_we  = 1'b0;
        case (t_action'(r_item.action))
            ACT_CHECK_RECORD: begin
                if (r_hit) begin
                    w_res.dup_found = 1'b1;
                    w_res.status    = 1'b1;
                end else begin
                    w_we = 1'b1;
                end
            end
            ACT_CHECK: begin
                w_res.dup_found = r_hit;
            end
            ACT_RECORD: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
        if (w_we) begin
            w_res.stored       = 1'b1;
            w_res.slot_written = w_slot_ext[6:0];
        end
    end

    // Entry memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DECIDE) && w_we) begin
            r_mem[w_slot] <= w_wdata;
        end
        if (r_state == S_SCAN) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    // Sequencer, scan accumulators and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_fill_ptr  <= '0;
            r_fill_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result taken; FINISH reloads it itself
            if (r_out_valid && !i_out_stall && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            r_rd_vld  <= (r_state == S_SCAN);
            r_cmp_idx <= r_rd_idx;

            // compare stage runs in the cycle after the read
            if (r_rd_vld) begin
                if (w_match) begin
                    r_hit <= 1'b1;
                end
                if (w_older) begin
                    r_best_ts  <= r_rd_data.ts;
                    r_best_idx <= r_cmp_idx;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_item   <= i_in_item;
                        r_hit    <= 1'b0;
                        r_rd_idx <= '0;
                        if (t_action'(i_in_item.action) == ACT_CLEAR) begin
                            r_fill_ptr <= '0;
                            r_fill_cnt <= '0;
                            r_res      <= '0;
                            r_state    <= S_FINISH;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_rd_idx == IDX_W'(WINDOW_DEPTH - 1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_res <= w_res;
                    if (w_we) begin
                        if (r_fill_ptr == IDX_W'(WINDOW_DEPTH - 1)) begin
                            r_fill_ptr <= '0;
                        end else begin
                            r_fill_ptr <= r_fill_ptr + 1'b1;
                        end
                        if (!w_full) begin
                            r_fill_cnt <= r_fill_cnt + 1'b1;
                        end
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_item  <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: design/dmwf_checker.sv
// ============================================================================
// dmwf_checker
// Port-level checks on the duplicate message window filter.
// ============================================================================
module dmwf_checker
    import dmwf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result changed while stalled");

    // An accepted item makes the block busy in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // A rejected duplicate never stores
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status) |-> (o_out_item.dup_found && !o_out_item.stored))
        else $error("rejected item reports a store");

    // Nothing stored means slot zero
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.stored) |-> (o_out_item.slot_written == 7'd0))
        else $error("slot reported without a store");

endmodule

bind duplicate_message_window_filter_unit dmwf_checker u_dmwf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

FILE: tb/tb_duplicate_message_window_filter_unit.sv
// ============================================================================
// tb_duplicate_message_window_filter_unit
// Self-checking bench for the duplicate message window filter. A short table
// of directed items covers the edge values, every action and a window clear.
// Random item sequences then refill the window, replay recent pairs and force
// oldest-entry eviction. Both sides idle at random. Each result is compared
// with a behavioural copy of the window.
// ============================================================================
module tb_duplicate_message_window_filter_unit;
    import dmwf_pkg::*;

    localparam int WINDOW       = 128;
    localparam int RANDOM_ITEMS = 1885;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int IDLE_PCT     = 36;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AT_ITEM = 400;
    localparam int DRAIN_AT     = 700;
    localparam int CALM_FROM    = 900;
    localparam int CALM_TO      = 1150;

    // One row of directed stimulus; res is used only where typed is set
    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item res;
    } t_step;

    typedef struct packed {
        logic [15:0] src;
        logic [63:0] msg;
    } t_pair;

    localparam t_step DIRECTED [15] = '{
        // empty window after reset
        '{'{ACT_CHECK,        16'h0000, 64'h0, 64'h0}, 1'b1, '{1'b0, 1'b0, 7'd0, 1'b0}},
        // all-ones pair goes into slot 0, then is seen again
        '{'{ACT_CHECK_RECORD, 16'hFFFF, '1, '1},       1'b1, '{1'b0, 1'b1, 7'd0, 1'b0}},
        '{'{ACT_CHECK_RECORD, 16'hFFFF, '1, 64'h0},    1'b1, '{1'b1, 1'b0, 7'd0, 1'b1}},
        '{'{ACT_CHECK,        16'hFFFF, '1, 64'h0},    1'b1, '{1'b1, 1'b0, 7'd0, 1'b0}},
        // near misses on message id and on source
        '{'{ACT_CHECK, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFE, 64'h0},
          1'b1, '{1'b0, 1'b0, 7'd0, 1'b0}},
        '{'{ACT_CHECK, 16'h7FFF, '1, 64'h0},           1'b1, '{1'b0, 1'b0, 7'd0, 1'b0}},
        // record only stores even when the pair is already there
        '{'{ACT_RECORD,       16'h0000, 64'h0, 64'h0}, 1'b1, '{1'b0, 1'b1, 7'd1, 1'b0}},
        '{'{ACT_RECORD,       16'h0000, 64'h0, 64'h0}, 1'b1, '{1'b0, 1'b1, 7'd2, 1'b0}},
        '{'{ACT_CHECK_RECORD, 16'h0000, 64'h0, 64'h1}, 1'b1, '{1'b1, 1'b0, 7'd0, 1'b1}},
        '{'{ACT_CHECK_RECORD, 16'h8000, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000},
          1'b1, '{1'b0, 1'b1, 7'd3, 1'b0}},
        '{'{ACT_CHECK_RECORD, 16'h0001, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
          1'b0, '0},
        // clear with busy fields, then the old pair is gone
        '{'{ACT_CLEAR,        16'hFFFF, '1, '1},       1'b1, '{1'b0, 1'b0, 7'd0, 1'b0}},
        '{'{ACT_CHECK,        16'hFFFF, '1, 64'h0},    1'b1, '{1'b0, 1'b0, 7'd0, 1'b0}},
        // ring order restarts at slot 0
        '{'{ACT_CHECK_RECORD, 16'h0000, 64'h0, 64'h0}, 1'b1, '{1'b0, 1'b1, 7'd0, 1'b0}},
        '{'{ACT_CHECK,        16'h0000, 64'h0, 64'h0}, 1'b0, '0}
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    // Copy of the window kept by the bench
    logic [15:0] win_src  [WINDOW];
    logic [63:0] win_msg  [WINDOW];
    logic [63:0] win_time [WINDOW];
    logic        win_valid[WINDOW];
    int unsigned ring_ptr;
    int unsigned occupancy;

    t_out_item   pending_q[$];
    t_pair       recent_q[$];
    t_out_item   want;
    logic [63:0] now_us       = 64'h0;
    int unsigned fail_cnt     = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned accepted_cnt = 0;
    int unsigned hold_left    = 0;
    logic        hold_done    = 1'b0;
    logic        calm         = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    duplicate_message_window_filter_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    function automatic void forget_window();
        for (int i = 0; i < WINDOW; i++) win_valid[i] = 1'b0;
        ring_ptr  = 0;
        occupancy = 0;
    endfunction

    function automatic logic pair_seen(input logic [15:0] src, input logic [63:0] msg);
        logic hit;
        hit = 1'b0;
        // full scan, no early exit
        for (int i = 0; i < WINDOW; i++)
            if (win_valid[i] && win_src[i] == src && win_msg[i] == msg) hit = 1'b1;
        return hit;
    endfunction

    // Store a pair: ring order until full, then the oldest entry, lowest index on ties
    function automatic int unsigned remember_pair(input logic [15:0] src,
                                                  input logic [63:0] msg,
                                                  input logic [63:0] ts);
        int unsigned slot;
        logic        found;
        slot  = ring_ptr % WINDOW;
        found = 1'b0;
        if (occupancy >= WINDOW) begin
            slot = 0;
            for (int i = 0; i < WINDOW; i++) begin
                if (!found) begin
                    if (!win_valid[i]) begin
                        slot  = i;
                        found = 1'b1;
                    end else if (win_time[i] < win_time[slot]) begin
                        slot = i;
                    end
                end
            end
        end
        win_src[slot]   = src;
        win_msg[slot]   = msg;
        win_time[slot]  = ts;
        win_valid[slot] = 1'b1;
        ring_ptr = (ring_ptr + 1) % WINDOW;
        if (occupancy < WINDOW) occupancy++;
        recent_q.push_back(t_pair'{src, msg});
        if (recent_q.size() > WINDOW) void'(recent_q.pop_front());
        return slot;
    endfunction

    function automatic t_out_item predict_result(input t_in_item it);
        t_out_item res;
        res = '0;
        case (t_action'(it.action))
            ACT_CHECK_RECORD: begin
                if (pair_seen(it.src_node, it.msg_id)) begin
                    res.dup_found = 1'b1;
                    res.status    = 1'b1;
                end else begin
                    res.slot_written = 7'(remember_pair(it.src_node, it.msg_id,
                                                        it.timestamp_us));
                    res.stored = 1'b1;
                end
            end
            ACT_CHECK: res.dup_found = pair_seen(it.src_node, it.msg_id);
            ACT_RECORD: begin
                res.slot_written = 7'(remember_pair(it.src_node, it.msg_id,
                                                    it.timestamp_us));
                res.stored = 1'b1;
            end
            ACT_CLEAR: forget_window();
            default: ;
        endcase
        return res;
    endfunction

    // Mostly lookups and stores of recent or small-range pairs, rare clears
    function automatic t_in_item next_random_item();
        t_in_item    it;
        t_pair       p;
        int unsigned pick;
        pick = $urandom_range(999);
        if (pick < 4) begin
            it.action = ACT_CLEAR;
        end else begin
            pick = $urandom_range(99);
            it.action = (pick < 60) ? ACT_CHECK_RECORD : (pick < 80) ? ACT_CHECK : ACT_RECORD;
        end
        pick = $urandom_range(99);
        if (pick < 40 && recent_q.size() != 0) begin
            p = recent_q[$urandom_range(recent_q.size() - 1)];
        end else if (pick < 70) begin
            p.src = 16'($urandom_range(7));
            p.msg = 64'($urandom_range(31));
        end else begin
            p.src = 16'($urandom);
            p.msg = {$urandom, $urandom};
        end
        it.src_node = p.src;
        it.msg_id   = p.msg;
        // slow clock with many ties, plus some wild values
        pick = $urandom_range(99);
        if (pick < 80) begin
            now_us = now_us + 64'($urandom_range(3));
            it.timestamp_us = now_us;
        end else if (pick < 88) begin
            it.timestamp_us = {$urandom, $urandom};
        end else if (pick < 92) begin
            it.timestamp_us = '0;
        end else if (pick < 96) begin
            it.timestamp_us = '1;
        end else begin
            it.timestamp_us = now_us;
        end
        return it;
    endfunction

    // Offer one item and hold it until accepted
    task automatic offer(input t_in_item it, input logic typed, input t_out_item res);
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        accepted_cnt++;
        if (typed) begin
            void'(predict_result(it));
            pending_q.push_back(res);
        end else begin
            pending_q.push_back(predict_result(it));
        end
    endtask

    // Stimulus
    initial begin
        forget_window();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        foreach (DIRECTED[k]) offer(DIRECTED[k].item, DIRECTED[k].typed, DIRECTED[k].res);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm <= (n >= CALM_FROM && n < CALM_TO);
            // sender pause until the block has drained
            if (n == DRAIN_AT) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_q.size() != 0) @(posedge clk);
            end
            offer(next_random_item(), 1'b0, '0);
        end
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (WINDOW + 8) @(posedge clk);
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver: random stalls, one long hold-off, a calm stretch
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && accepted_cnt >= HOLD_AT_ITEM) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_q.size() == 0) begin
                $error("result with nothing expected: %p", out_item);
                fail_cnt++;
            end else begin
                want = pending_q.pop_front();
                if (out_item.dup_found !== want.dup_found) begin
                    $error("dup_found: expected %0d, got %0d",
                           want.dup_found, out_item.dup_found);
                    fail_cnt++;
                end
                if (out_item.stored !== want.stored) begin
                    $error("stored: expected %0d, got %0d", want.stored, out_item.stored);
                    fail_cnt++;
                end
                if (out_item.slot_written !== want.slot_written) begin
                    $error("slot_written: expected %0d, got %0d",
                           want.slot_written, out_item.slot_written);
                    fail_cnt++;
                end
                if (out_item.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_item.status);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
design/dmwf_pkg.sv
design/duplicate_message_window_filter_unit.sv
design/dmwf_checker.sv
tb/tb_duplicate_message_window_filter_unit.sv
